@@ src/quadtree_patch_phase_rasterizer_defines.svh @@
// ----------------------------------------------------------------------------
// quadtree patch phase rasterizer assertion macros
// concurrent assertion wrappers, compiled out when ASSERT_OFF is defined
// ----------------------------------------------------------------------------
`ifndef QUADTREE_PATCH_PHASE_RASTERIZER_DEFINES_SVH
`define QUADTREE_PATCH_PHASE_RASTERIZER_DEFINES_SVH

`ifndef ASSERT_OFF
// property checked on every rising edge of clk_i outside reset
`define QPPR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// expression that must never hold outside reset
`define QPPR_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);
`else
`define QPPR_ASSERT(lbl, prop, msg)
`define QPPR_ASSERT_NEVER(lbl, expr, msg)
`endif

`endif

@@ src/qppr_pkg.sv @@
// ----------------------------------------------------------------------------
// qppr_pkg
// shared constants, types and pixel rounding for the patch rasterizer
// ----------------------------------------------------------------------------
package qppr_pkg;

  localparam int MAX_COLS    = 256;
  localparam int MAX_ROWS    = 256;
  localparam int STORE_DEPTH = MAX_COLS * MAX_ROWS;
  localparam int STORE_AW    = $clog2(STORE_DEPTH);

  localparam int PIX_W   = 8;
  localparam int NACC_W  = 27;  // planar numerator, worst case about 2^25
  localparam int KADDR_W = 20;  // running linear address before bound check
  localparam int NPIX_W  = 18;  // cols * rows with 9 bit registers

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SU_NPIX,
    ST_SU_ROW,
    ST_SU_GX,
    ST_SU_GY,
    ST_SU_BASE,
    ST_FILL,
    ST_READ,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_BOUNDS = 2'd1,
    STAT_REJECT = 2'd2
  } status_e;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_READ  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    CFG_COLS     = 2'd0,
    CFG_ROWS     = 2'd1,
    CFG_FLAT     = 2'd2,
    CFG_EXPECTED = 2'd3
  } cfg_reg_e;

  // n / 512 rounded half to even, wrapped to 8 bits
  function automatic logic [PIX_W-1:0] round_wrap(input logic [NACC_W-1:0] n);
    logic inc;
    inc = (n[8:0] > 9'd256) || ((n[8:0] == 9'd256) && n[9]);
    return n[16:9] + {{(PIX_W-1){1'b0}}, inc};
  endfunction

endpackage

@@ src/qppr_ram.sv @@
// ----------------------------------------------------------------------------
// qppr_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module qppr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/quadtree_patch_phase_rasterizer.sv @@
// ----------------------------------------------------------------------------
// quadtree_patch_phase_rasterizer
// paints square phase patches into a frame store and reads pixels back
// ----------------------------------------------------------------------------
// usage
//   s_axis carries one item per transfer: tuser selects write patch or read
//   pixel, tdata holds the patch record and the read address
//   m_axis returns exactly one result per item: pixel value, status, patch
//   count and count match flag
//   cfg channel writes image_cols, image_rows, flat_mode, expected_patches;
//   always ready, write only while the block is idle
// processing
//   a patch runs the setup states SU_NPIX, SU_ROW, SU_GX, SU_GY and SU_BASE;
//   SU_NPIX to SU_GY share one 10x17 multiplier, then the fill writes one pixel
//   per cycle through the single frame store write port
//   a read passes READ (registered ram read); rejected or empty patches skip setup
//   one item is in work at a time; a new item is taken while the previous
//   result still waits in the output register
// reset
//   after rst_ni releases, the frame store is cleared one pixel per cycle,
//   all 65536 pixels whatever the size registers hold; s_axis_tready stays low
// stall
//   if m_axis_tready is low, the finished item waits in its done state and
//   the next input is held off until the output register frees up
// ----------------------------------------------------------------------------
`include "quadtree_patch_phase_rasterizer_defines.svh"

module quadtree_patch_phase_rasterizer
  import qppr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // config write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  // input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] corner_col, [15:8] corner_row, [24:16] patch_size,
  // [40:25] mean_phase, [56:41] grad_x, [72:57] grad_y, [88:73] pixel_index
  input  logic [95:0] s_axis_tdata,
  // [0] op
  input  logic        s_axis_tuser,
  // results
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] pixel_value, [9:8] status, [25:10] patches_seen, [26] count_matches
  output logic [31:0] m_axis_tdata
);

  // input field unpack
  logic               in_op;
  logic [7:0]         in_corner_col;
  logic [7:0]         in_corner_row;
  logic [8:0]         in_patch_size;
  logic signed [15:0] in_mean_phase;
  logic signed [15:0] in_grad_x;
  logic signed [15:0] in_grad_y;
  logic [15:0]        in_pixel_index;

  assign in_op          = s_axis_tuser;
  assign in_corner_col  = s_axis_tdata[7:0];
  assign in_corner_row  = s_axis_tdata[15:8];
  assign in_patch_size  = s_axis_tdata[24:16];
  assign in_mean_phase  = s_axis_tdata[40:25];
  assign in_grad_x      = s_axis_tdata[56:41];
  assign in_grad_y      = s_axis_tdata[72:57];
  assign in_pixel_index = s_axis_tdata[88:73];

  // config registers
  logic [8:0]  cols_q, rows_q;
  logic        flat_q;
  logic [15:0] exp_q;

  // control state
  state_e              state_q, state_d;
  logic [STORE_AW-1:0] clr_q;
  logic                err_q;
  logic [15:0]         cnt_q;
  logic                m_valid_q;

  // patch record
  logic [7:0]         c0_q, r0_q;
  logic [8:0]         w_q;
  logic signed [15:0] mean_q, gx_q, gy_q;
  logic               rd_in_range_q;

  // setup and fill datapath
  logic signed [9:0]        mul_a;
  logic signed [16:0]       mul_b;
  logic signed [NACC_W-1:0] mul_prod, mul_q;
  logic [NPIX_W-1:0]        npix_q;
  logic [KADDR_W-1:0]       rowk_q, k_q;
  logic signed [NACC_W-1:0] px_q, rown_q, acc_q;
  logic [8:0]               dx_q, dy_q;

  // finished item waiting for the output register
  logic [PIX_W-1:0] done_pix_q;
  status_e          done_status_q;
  logic             done_cnt_q;

  // output register
  logic [PIX_W-1:0] out_pix_q;
  status_e          out_status_q;
  logic [15:0]      out_cnt_q;
  logic             out_match_q;

  // derived
  logic [8:0]               cols_sat, rows_sat, wm1;
  logic signed [NACC_W-1:0] gx2, gy2, mean2;
  logic                     s_acc, out_free, out_load;
  logic                     fault, row_end, last_pix;
  logic [15:0]              cnt_next;

  // frame store ports
  logic                mem_we, mem_re;
  logic [STORE_AW-1:0] mem_waddr, mem_raddr;
  logic [PIX_W-1:0]    mem_wdata, mem_rdata;

  assign cols_sat = (32'(cols_q) > MAX_COLS) ? 9'(MAX_COLS) : cols_q;
  assign rows_sat = (32'(rows_q) > MAX_ROWS) ? 9'(MAX_ROWS) : rows_q;
  assign wm1      = w_q - 9'd1;

  // doubled steps, sign extended to accumulator width
  assign gx2   = {{(NACC_W-17){gx_q[15]}}, gx_q, 1'b0};
  assign gy2   = {{(NACC_W-17){gy_q[15]}}, gy_q, 1'b0};
  assign mean2 = {{(NACC_W-17){mean_q[15]}}, mean_q, 1'b0};

  assign s_acc    = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_valid_q || m_axis_tready;

  // fill position checks
  assign fault    = (k_q >= KADDR_W'(npix_q));
  assign row_end  = (dx_q == wm1);
  assign last_pix = row_end && (dy_q == wm1);

  assign cnt_next = (done_cnt_q && (cnt_q != 16'hFFFF)) ? cnt_q + 16'd1 : cnt_q;

  // shared setup multiplier: npix, row address, x and y half-span terms
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ST_SU_NPIX: begin
        mul_a = {1'b0, cols_sat};
        mul_b = {8'b0, rows_sat};
      end
      ST_SU_ROW: begin
        mul_a = {1'b0, cols_sat};
        mul_b = {9'b0, r0_q};
      end
      ST_SU_GX: begin
        mul_a = {1'b0, wm1};
        mul_b = {gx_q[15], gx_q};
      end
      ST_SU_GY: begin
        mul_a = {1'b0, wm1};
        mul_b = {gy_q[15], gy_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_prod = NACC_W'(mul_a) * NACC_W'(mul_b);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_q == STORE_AW'(STORE_DEPTH - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (s_acc) begin
          priority if (op_e'(in_op) == OP_READ) state_d = ST_READ;
          else if (err_q) state_d = ST_DONE;
          else if (in_patch_size == 9'd0) state_d = ST_DONE;
          else state_d = ST_SU_NPIX;
        end
      end
      ST_SU_NPIX: state_d = ST_SU_ROW;
      ST_SU_ROW:  state_d = ST_SU_GX;
      ST_SU_GX:   state_d = ST_SU_GY;
      ST_SU_GY:   state_d = ST_SU_BASE;
      ST_SU_BASE: state_d = ST_FILL;
      ST_FILL: begin
        if (fault || last_pix) state_d = ST_DONE;
      end
      ST_READ: state_d = ST_DONE;
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs of the state machine: handshakes and frame store access
  always_comb begin
    s_axis_tready = 1'b0;
    out_load      = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = '0;
    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
      end
      ST_IDLE: s_axis_tready = 1'b1;
      ST_FILL: begin
        mem_we    = !fault;
        mem_waddr = STORE_AW'(k_q);
        mem_wdata = round_wrap(acc_q);
      end
      ST_DONE: out_load = out_free;
      default: begin
        s_axis_tready = 1'b0;
      end
    endcase
  end

  assign mem_re    = s_acc && (op_e'(in_op) == OP_READ);
  assign mem_raddr = STORE_AW'(in_pixel_index);

  qppr_ram #(
    .WIDTH (PIX_W),
    .DEPTH (STORE_DEPTH)
  ) u_frame_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_q     <= '0;
      err_q     <= 1'b0;
      cnt_q     <= '0;
      m_valid_q <= 1'b0;
      cols_q    <= 9'd256;
      rows_q    <= 9'd256;
      flat_q    <= 1'b0;
      exp_q     <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) clr_q <= clr_q + STORE_AW'(1);
      if (out_load) begin
        cnt_q <= cnt_next;
        if (done_status_q == STAT_BOUNDS) err_q <= 1'b1;
      end
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_reg_e'(cfg_index_i))
          CFG_COLS:     cols_q <= cfg_data_i[8:0];
          CFG_ROWS:     rows_q <= cfg_data_i[8:0];
          CFG_FLAT:     flat_q <= cfg_data_i[0];
          CFG_EXPECTED: exp_q  <= cfg_data_i;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    mul_q <= mul_prod;
    if (s_acc) begin
      c0_q          <= in_corner_col;
      r0_q          <= in_corner_row;
      w_q           <= in_patch_size;
      mean_q        <= in_mean_phase;
      gx_q          <= flat_q ? 16'sd0 : in_grad_x;
      gy_q          <= flat_q ? 16'sd0 : in_grad_y;
      rd_in_range_q <= (32'(in_pixel_index) < STORE_DEPTH);
      done_pix_q    <= '0;
      done_status_q <= STAT_OK;
      done_cnt_q    <= 1'b0;
      if (op_e'(in_op) == OP_WRITE) begin
        // latched error rejects, an empty patch counts at once
        if (err_q) begin
          done_status_q <= STAT_REJECT;
        end else if (in_patch_size == 9'd0) begin
          done_cnt_q <= 1'b1;
        end
      end
    end
    unique case (state_q)
      ST_SU_ROW: npix_q <= NPIX_W'(mul_q);
      ST_SU_GX:  rowk_q <= KADDR_W'(mul_q) + KADDR_W'(c0_q);
      ST_SU_GY:  px_q   <= mul_q;
      ST_SU_BASE: begin
        // first row start: 2*mean - (w-1)*gx - (w-1)*gy
        rown_q <= mean2 - px_q - mul_q;
        acc_q  <= mean2 - px_q - mul_q;
        k_q    <= rowk_q;
        dx_q   <= '0;
        dy_q   <= '0;
      end
      ST_FILL: begin
        if (fault) begin
          done_status_q <= STAT_BOUNDS;
        end else if (last_pix) begin
          done_cnt_q <= 1'b1;
        end else if (!row_end) begin
          acc_q <= acc_q + gx2;
          k_q   <= k_q + KADDR_W'(1);
          dx_q  <= dx_q + 9'd1;
        end else begin
          // next row of the patch
          dx_q   <= '0;
          dy_q   <= dy_q + 9'd1;
          rowk_q <= rowk_q + KADDR_W'(cols_sat);
          k_q    <= rowk_q + KADDR_W'(cols_sat);
          rown_q <= rown_q + gy2;
          acc_q  <= rown_q + gy2;
        end
      end
      ST_READ: done_pix_q <= rd_in_range_q ? mem_rdata : '0;
      default: begin
      end
    endcase
    if (out_load) begin
      out_pix_q    <= done_pix_q;
      out_status_q <= done_status_q;
      out_cnt_q    <= cnt_next;
      out_match_q  <= (cnt_next == exp_q);
    end
  end

  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {5'b0, out_match_q, out_cnt_q, out_status_q, out_pix_q};

  // fill never writes at or past the image pixel count
  `QPPR_ASSERT(a_fill_in_bounds, (state_q == ST_FILL && mem_we) |-> (k_q < KADDR_W'(npix_q)), "fill write past image")
  // only reset clears the error latch
  `QPPR_ASSERT(a_err_sticky, err_q |=> err_q, "error latch dropped")
  // one item in work: no transfer right after a transfer
  `QPPR_ASSERT(a_single_item, s_acc |=> !s_axis_tready, "second item taken while busy")
  // patch counter moves by at most one, only when a result is loaded
  `QPPR_ASSERT(a_cnt_step, (cnt_q != $past(cnt_q)) |-> ((cnt_q == $past(cnt_q) + 16'd1) && $past(out_load)), "patch counter jumped")

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: quadtree patch phase rasterizer testbench
// drives patch and pixel-read transfers with random idling, paints its own
// copy of the frame and checks every returned result field by field
// ----------------------------------------------------------------------------
module tb;
  import qppr_pkg::*;

  // bound above the slowest legal run: the clear pass, one whole-image fill,
  // a 200-square and 1400 items at worst stalls
  localparam int unsigned RUN_LIMIT = 3_000_000;
  localparam int unsigned HOLD_CYC  = 400;  // long receiver hold-off
  localparam int unsigned SETTLE_CYC = 12;

  // one input item, fields as in the tdata / tuser layout
  typedef struct packed {
    op_e         op;
    logic [7:0]  col;
    logic [7:0]  row;
    logic [8:0]  size;
    logic [15:0] mean;
    logic [15:0] gx;
    logic [15:0] gy;
    logic [15:0] idx;
  } patch_item_t;

  // one result, laid out exactly like m_axis_tdata[26:0]
  typedef struct packed {
    logic        match;
    logic [15:0] seen;
    status_e     st;
    logic [7:0]  pix;
  } item_report_t;

  typedef struct {
    patch_item_t  it;
    bit           typed;
    item_report_t want;
  } dir_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;

  // own copy of the block state
  logic [7:0]  phase_img [STORE_DEPTH];
  logic [15:0] patch_total;
  bit          latched_fault;
  logic [8:0]  reg_cols;
  logic [8:0]  reg_rows;
  logic        reg_flat;
  logic [15:0] reg_expect;

  item_report_t item_report_q[$];
  dir_row_t     dir_rows[$];
  int unsigned  mismatch_cnt;
  int unsigned  cycle_cnt;
  bit           idle_on = 1'b1;
  bit           hold_req = 1'b0;
  item_report_t got;
  item_report_t want;

  quadtree_patch_phase_rasterizer i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= RUN_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // size registers saturate at the store dimensions
  function automatic int unsigned clamp_cols();
    return (reg_cols > MAX_COLS) ? MAX_COLS : reg_cols;
  endfunction

  function automatic int unsigned clamp_rows();
    return (reg_rows > MAX_ROWS) ? MAX_ROWS : reg_rows;
  endfunction

  // paint a patch or fetch a pixel, returns the result the block must give
  function automatic item_report_t rasterize(input patch_item_t it);
    item_report_t r;
    int unsigned  cols;
    int unsigned  npix;
    longint       w, mean, gx, gy, n, q, rem, k;
    bit           fault;
    r = '0;
    fault = 1'b0;
    cols = clamp_cols();
    npix = cols * clamp_rows();
    if (it.op == OP_READ) begin
      r.pix = phase_img[it.idx];
    end else if (latched_fault) begin
      r.st = STAT_REJECT;
    end else begin
      w = it.size;
      mean = $signed(it.mean);
      gx = reg_flat ? 0 : longint'($signed(it.gx));
      gy = reg_flat ? 0 : longint'($signed(it.gy));
      // raster order, rows outer; stop at the first address past the image
      for (longint dy = 0; dy < w && !fault; dy++) begin
        for (longint dx = 0; dx < w && !fault; dx++) begin
          k = (longint'(it.col) + dx) + (longint'(it.row) + dy) * longint'(cols);
          if (k >= longint'(npix)) begin
            fault = 1'b1;
          end else begin
            n = 2 * mean + (2 * dx - (w - 1)) * gx + (2 * dy - (w - 1)) * gy;
            // floor by 512, then round half to even
            q = n >>> 9;
            rem = n - q * 512;
            if (rem > 256 || (rem == 256 && q[0])) q++;
            phase_img[k] = q[7:0];
          end
        end
      end
      if (fault) begin
        latched_fault = 1'b1;
        r.st = STAT_BOUNDS;
      end else if (patch_total != 16'hFFFF) begin
        patch_total++;
      end
    end
    r.seen = patch_total;
    r.match = (patch_total == reg_expect);
    return r;
  endfunction

  function automatic patch_item_t patch(input logic [7:0] c, r, input logic [8:0] w,
                                        input logic [15:0] m, x, y);
    return '{OP_WRITE, c, r, w, m, x, y, 16'd0};
  endfunction

  function automatic patch_item_t pix_read(input logic [15:0] a);
    return '{OP_READ, 8'd0, 8'd0, 9'd0, 16'd0, 16'd0, 16'd0, a};
  endfunction

  // random item; patches are fitted inside the image so the fault latch
  // stays clear, big sets the side length before fitting shrinks it if needed
  function automatic patch_item_t rand_item(input int unsigned big);
    patch_item_t it;
    int unsigned cols, npix, w, pick, span, rmax, cmax;
    cols = clamp_cols();
    npix = cols * clamp_rows();
    it.col = 8'($urandom);
    it.row = 8'($urandom);
    it.size = 9'($urandom);
    it.mean = 16'($urandom);
    it.gx = 16'($urandom);
    it.gy = 16'($urandom);
    it.idx = 16'($urandom);
    if ($urandom_range(0, 9) == 0) it.mean = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
    if ($urandom_range(0, 9) == 0) it.gx = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
    if ($urandom_range(0, 9) == 0) it.gy = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
    it.op = (big == 0 && $urandom_range(0, 99) < 45) ? OP_READ : OP_WRITE;
    if (it.op == OP_READ) begin
      if (npix != 0 && $urandom_range(0, 9) < 7) it.idx = 16'($urandom_range(0, npix - 1));
    end else if (npix != 0 && !latched_fault) begin
      pick = $urandom_range(0, 99);
      if (big != 0) w = big;
      else if (pick < 8) w = 0;
      else if (pick < 68) w = $urandom_range(1, 4);
      else if (pick < 96) w = $urandom_range(5, 16);
      else w = $urandom_range(17, 40);
      while (w > 1 && (w - 1) * (cols + 1) > npix - 1) w--;
      it.size = 9'(w);
      if (w != 0) begin
        // last pixel sits at corner + (w-1)*(cols+1); columns may spill over
        span = (w - 1) * (cols + 1);
        rmax = (npix - 1 - span) / cols;
        if (rmax > 255) rmax = 255;
        it.row = 8'($urandom_range(0, rmax));
        cmax = npix - 1 - (w - 1) - (it.row + w - 1) * cols;
        if (cmax > 255) cmax = 255;
        it.col = 8'($urandom_range(0, cmax));
      end
    end
    return it;
  endfunction

  // offer one item until the transfer happens, then log its expectation
  task automatic put_item(input patch_item_t it, input bit typed, input item_report_t fixed);
    item_report_t r;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= it.op;
    s_axis_tdata <= {7'd0, it.idx, it.gy, it.gx, it.mean, it.size, it.row, it.col};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    r = rasterize(it);
    item_report_q.push_back(typed ? fixed : r);
  endtask

  task automatic maybe_pause();
    if (idle_on && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
  endtask

  // stop offering, wait for every result, then let the block go quiet
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (item_report_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  // writes all four registers, block must be idle
  task automatic program_regs(input logic [15:0] cols, rows, input logic flat,
                              input logic [15:0] want_cnt);
    cfg_reg_e    regs [4] = '{CFG_COLS, CFG_ROWS, CFG_FLAT, CFG_EXPECTED};
    logic [15:0] vals [4];
    vals = '{cols, rows, {15'd0, flat}, want_cnt};
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= regs[i];
      cfg_data <= vals[i];
      @(posedge clk_i);
      while (!cfg_ready) @(posedge clk_i);
      case (regs[i])
        CFG_COLS: reg_cols = vals[i][8:0];
        CFG_ROWS: reg_rows = vals[i][8:0];
        CFG_FLAT: reg_flat = vals[i][0];
        default:  reg_expect = vals[i];
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = item_report_t'(m_axis_tdata[26:0]);
      if (item_report_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("cycle %0d: result transfer with nothing pending: pix %0d st %0d seen %0d",
                   cycle_cnt, $signed(got.pix), got.st, got.seen);
      end else begin
        want = item_report_q.pop_front();
        if (got.pix !== want.pix || got.st !== want.st || got.seen !== want.seen ||
            got.match !== want.match) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("cycle %0d: expected pix %0d st %0d seen %0d match %0b, got %0d %0d %0d %0b",
                     cycle_cnt, $signed(want.pix), want.st, want.seen, want.match,
                     $signed(got.pix), got.st, got.seen, got.match);
        end
      end
    end
  end

  // receiver: random stalls, plus one long hold so the block backs up
  initial begin
    m_axis_tready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYC) @(posedge clk_i);
        hold_req = 1'b0;
        m_axis_tready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // stimulus
  initial begin
    int unsigned n_items;
    patch_item_t item;

    rst_ni <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_COLS;
    cfg_data <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tuser <= OP_WRITE;
    cycle_cnt = 0;
    mismatch_cnt = 0;
    foreach (phase_img[i]) phase_img[i] = '0;
    patch_total = '0;
    latched_fault = 1'b0;
    reg_cols = 9'd256;
    reg_rows = 9'd256;
    reg_flat = 1'b0;
    reg_expect = '0;

    // directed part, reset register values
    // fresh store and counter: zero pixels, count 0 equals expected 0
    dir_rows.push_back('{pix_read(16'd0), 1'b1, '{1'b1, 16'd0, STAT_OK, 8'h00}});
    dir_rows.push_back('{pix_read(16'hFFFF), 1'b1, '{1'b1, 16'd0, STAT_OK, 8'h00}});
    // empty patch counts even at the far corner
    dir_rows.push_back('{patch(8'd255, 8'd255, 9'd0, 16'h7FFF, 16'h0, 16'h0), 1'b1,
                         '{1'b0, 16'd1, STAT_OK, 8'h00}});
    // phase extremes both give 0x80: the top one rounds up to +128 and wraps
    dir_rows.push_back('{patch(8'd0, 8'd0, 9'd1, 16'h7FFF, 16'h8000, 16'h7FFF), 1'b0, '0});
    dir_rows.push_back('{pix_read(16'd0), 1'b0, '0});
    dir_rows.push_back('{patch(8'd255, 8'd255, 9'd1, 16'h8000, 16'h7FFF, 16'h8000), 1'b0, '0});
    dir_rows.push_back('{pix_read(16'hFFFF), 1'b0, '0});
    // gradient extremes on a 2x2 patch
    dir_rows.push_back('{patch(8'd10, 8'd3, 9'd2, 16'h0, 16'h7FFF, 16'h8000), 1'b0, '0});
    dir_rows.push_back('{pix_read(16'd778), 1'b0, '0});
    dir_rows.push_back('{pix_read(16'd779), 1'b0, '0});
    dir_rows.push_back('{pix_read(16'd1034), 1'b0, '0});
    dir_rows.push_back('{pix_read(16'd1035), 1'b0, '0});
    // exact halves: +0.5, +1.5, -0.5, -1.5
    dir_rows.push_back('{patch(8'd1, 8'd0, 9'd1, 16'd128, 16'h0, 16'h0), 1'b0, '0});
    dir_rows.push_back('{patch(8'd2, 8'd0, 9'd1, 16'd384, 16'h0, 16'h0), 1'b0, '0});
    dir_rows.push_back('{patch(8'd3, 8'd0, 9'd1, 16'hFF80, 16'h0, 16'h0), 1'b0, '0});
    dir_rows.push_back('{patch(8'd4, 8'd0, 9'd1, 16'hFE80, 16'h0, 16'h0), 1'b0, '0});
    dir_rows.push_back('{pix_read(16'd1), 1'b0, '0});
    dir_rows.push_back('{pix_read(16'd2), 1'b0, '0});
    dir_rows.push_back('{pix_read(16'd3), 1'b0, '0});
    dir_rows.push_back('{pix_read(16'd4), 1'b0, '0});
    // columns past the row end spill into the next row
    dir_rows.push_back('{patch(8'd250, 8'd5, 9'd10, 16'd1000, 16'd300, 16'hFF38), 1'b0, '0});
    dir_rows.push_back('{pix_read(16'd1537), 1'b0, '0});
    // largest patch covers the whole image
    dir_rows.push_back('{patch(8'd0, 8'd0, 9'd256, 16'h1234, 16'h0101, 16'hFF00), 1'b0, '0});
    dir_rows.push_back('{pix_read(16'hFFFF), 1'b0, '0});
    dir_rows.push_back('{pix_read(16'd32896), 1'b0, '0});

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // first transfer waits out the clear pass
    foreach (dir_rows[i]) begin
      maybe_pause();
      put_item(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].want);
    end

    // random phases, each under its own register setting
    for (int p = 0; p < 5; p++) begin
      settle();
      case (p)
        0: begin
          // oversized registers saturate to the store size
          program_regs(16'hFFFF, 16'd300, 1'b1, patch_total + 16'd5);
          n_items = 260;
        end
        1: begin
          program_regs(16'd1, 16'd1, 1'b0, patch_total + 16'd3);
          n_items = 150;
        end
        2: begin
          program_regs(16'd256, 16'd256, 1'b0, 16'd0);
          n_items = 300;
        end
        3: begin
          program_regs(16'd37, 16'd200, 1'b1, patch_total + 16'd40);
          n_items = 250;
        end
        default: begin
          program_regs(16'($urandom_range(1, 256)), 16'($urandom_range(1, 256)),
                       1'($urandom_range(0, 1)), patch_total + 16'($urandom_range(0, 30)));
          n_items = 370;
        end
      endcase
      for (int i = 0; i < n_items; i++) begin
        if (p == 2 && i == 40) hold_req = 1'b1;
        if (p == 4 && i == 100) idle_on = 1'b0;
        maybe_pause();
        put_item(rand_item((p == 2 && i == 150) ? 200 : 0), 1'b0, '0);
      end
    end

    // zero columns: no pixel fits, yet an empty patch still passes
    settle();
    program_regs(16'd0, 16'd256, 1'b0, patch_total + 16'd1);
    item = rand_item(0);
    item.op = OP_WRITE;
    item.size = '0;
    put_item(item, 1'b0, '0);

    // oversized patch runs off the image end part way: partial write, latch set
    settle();
    program_regs(16'd100, 16'd50, 1'($urandom_range(0, 1)), 16'd0);
    item = rand_item(0);
    item.op = OP_WRITE;
    item.col = 8'd90;
    item.row = 8'd40;
    item.size = 9'd511;
    put_item(item, 1'b0, '0);
    for (int i = 0; i < 30; i++) begin
      item = rand_item(0);
      if (item.op == OP_READ) item.idx = 16'($urandom_range(3990, 5100));
      put_item(item, 1'b0, '0);
    end

    // latch survives any register setting
    settle();
    program_regs(16'd256, 16'd0, 1'b1, 16'hFFFF);
    for (int i = 0; i < 10; i++) put_item(rand_item(0), 1'b0, '0);

    settle();
    if (mismatch_cnt == 0 && item_report_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
